@@ rtl/ppl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppl_pkg
// widths, register map and shared types of the power peak locator
// ----------------------------------------------------------------------------
package ppl_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 16;
  localparam int PWR_W      = 32;
  localparam int OFF_W      = 18;
  localparam int FRAC_STEPS = 16;
  localparam int QUO_W      = FRAC_STEPS + 1;
  localparam int DIV_W      = PWR_W + 6;
  localparam int STEP_W     = $clog2(FRAC_STEPS);

  localparam int IN_DATA_W  = 2 * SAMPLE_W;
  localparam int RES_W      = IDX_W + OFF_W + PWR_W + 2;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_WIN_LOW   = 2'd0;
  localparam logic [1:0] REG_WIN_HIGH  = 2'd1;
  localparam logic [1:0] REG_LOCAL_MAX = 2'd2;

  localparam logic [IDX_W-1:0] WIN_LOW_RST  = IDX_W'(1);
  localparam logic [IDX_W-1:0] WIN_HIGH_RST = IDX_W'(65534);

  typedef struct packed {
    logic             done;
    logic             flat;
    logic [OFF_W-1:0] offset;
  } ppl_div_res_t;

endpackage
`default_nettype wire

@@ rtl/ppl_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppl_divider
// restoring divider for the parabola vertex offset, one quotient bit a cycle
// ----------------------------------------------------------------------------
module ppl_divider (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [ppl_pkg::PWR_W-1:0]   yl,
  input  wire [ppl_pkg::PWR_W-1:0]   yp,
  input  wire [ppl_pkg::PWR_W-1:0]   yr,
  output ppl_pkg::ppl_div_res_t      res
);
  import ppl_pkg::*;

  logic signed [PWR_W+1:0] num_s;
  logic signed [DIV_W-1:0] curv_s;
  logic signed [DIV_W-1:0] den_s;
  logic [DIV_W-1:0]        an_w;
  logic [DIV_W-1:0]        ad_w;
  logic [DIV_W-1:0]        rem_shift;
  logic [QUO_W-1:0]        q_sel;
  logic [OFF_W-1:0]        q_ext;

  logic                    busy_r;
  logic                    done_r;
  logic [STEP_W-1:0]       cnt_r;
  logic [DIV_W-1:0]        rem_r;
  logic [DIV_W-1:0]        ad_r;
  logic [QUO_W-1:0]        q_r;
  logic                    neg_r;
  logic                    flat_r;
  logic                    sat_r;

  always_comb begin
    num_s  = $signed({2'b00, yl}) - $signed({2'b00, yr});
    curv_s = $signed({{(DIV_W-PWR_W){1'b0}}, yl}) + $signed({{(DIV_W-PWR_W){1'b0}}, yr})
           - $signed({{(DIV_W-PWR_W-1){1'b0}}, yp, 1'b0});
    den_s  = curv_s <<< 1;
    an_w   = num_s[PWR_W+1] ? DIV_W'(-num_s) : DIV_W'(num_s);
    ad_w   = den_s[DIV_W-1] ? DIV_W'(-den_s) : DIV_W'(den_s);
    rem_shift = {rem_r[DIV_W-2:0], 1'b0};
    q_sel  = sat_r ? QUO_W'(1 << FRAC_STEPS) : q_r;
    q_ext  = OFF_W'(q_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(FRAC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= an_w;
      ad_r   <= ad_w;
      q_r    <= '0;
      neg_r  <= num_s[PWR_W+1] ^ den_s[DIV_W-1];
      flat_r <= (den_s == '0);
      sat_r  <= (an_w >= ad_w);
    end else if (busy_r) begin
      if (rem_shift >= ad_r) begin
        rem_r <= rem_shift - ad_r;
        q_r   <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_shift;
        q_r   <= {q_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    res.done   = done_r;
    res.flat   = flat_r;
    if (flat_r) begin
      res.offset = '0;
    end else if (neg_r) begin
      res.offset = OFF_W'(-q_ext);
    end else begin
      res.offset = q_ext;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still iterating");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == '0)
    else $error("divider did not start iterating");

  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && flat_r |-> res.offset == '0)
    else $error("flat fit with nonzero offset");

endmodule
`default_nettype wire

@@ rtl/power_peak_parabolic_locator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// power_peak_parabolic_locator
// power peak search over a frame of i/q samples with parabolic refinement
//
// input beats carry one sample each (i in tdata[15:0], q in tdata[31:16]) and
// in_tlast marks the final sample of a frame. one output beat is sent per
// frame, after its last sample: peak index, vertex offset in 1/65536 sample,
// peak power and the found and flat flags.
// for each sample one shared 16x16 squarer forms i*i and then q*q, and a
// compare step updates the best candidate; in_tready is high only between
// samples. after the last sample the offset comes from a restoring divider,
// one quotient bit a cycle; the divider is skipped when no candidate was
// found in the frame. window and mode registers sit on the apb port; the
// user must write them only while idle, as the block itself does not
// enforce it. reset is synchronous: registers return to window 1..65534
// with local max mode and the frame state clears. if the receiver stalls,
// the result is held in the output register and the next frame's samples
// are still taken; a further result waits until the held one is taken.
// ----------------------------------------------------------------------------
module power_peak_parabolic_locator (
  input  wire                                clk,
  input  wire                                rst_n,
  // slave side: [15:0] sample_i, [31:16] sample_q
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [ppl_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire                                in_tlast,
  // master side: [15:0] peak_index, [33:16] peak_offset, [65:34] peak_power,
  // [66] peak_found, [67] flat_fit, [71:68] zero
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [ppl_pkg::OUT_DATA_W-1:0]     out_tdata,
  // configuration
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire [ppl_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire [ppl_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [ppl_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import ppl_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQI   = 3'd1;
  localparam logic [2:0] ST_SQQ   = 3'd2;
  localparam logic [2:0] ST_JUDGE = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;

  logic [IDX_W-1:0]    win_low_r;
  logic [IDX_W-1:0]    win_high_r;
  logic                local_max_r;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;

  logic [SAMPLE_W-1:0] smp_i_r;
  logic [SAMPLE_W-1:0] smp_q_r;
  logic                last_r;

  logic [SAMPLE_W-1:0] mul_sel;
  logic [SAMPLE_W-1:0] mag;
  logic [PWR_W-1:0]    sq;
  logic [PWR_W-1:0]    acc_r;

  logic [IDX_W-1:0]    cnt_r;
  logic [PWR_W-1:0]    pd1_r;
  logic [PWR_W-1:0]    pd2_r;
  logic [PWR_W-1:0]    best_pwr_r;
  logic [IDX_W-1:0]    best_pos_r;
  logic [PWR_W-1:0]    best_l_r;
  logic [PWR_W-1:0]    best_r_r;
  logic                cand_r;

  logic [IDX_W-1:0]    lo_eff;
  logic [IDX_W-1:0]    cur_idx;
  logic                qualify;

  logic [OFF_W-1:0]    res_off_r;
  logic                res_flat_r;
  logic                div_start;
  ppl_div_res_t        div_res;

  logic                out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                in_acc;
  logic                out_load;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_WIN_LOW:   cfg_prdata = CFG_DATA_W'(win_low_r);
      REG_WIN_HIGH:  cfg_prdata = CFG_DATA_W'(win_high_r);
      REG_LOCAL_MAX: cfg_prdata = CFG_DATA_W'(local_max_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r   <= WIN_LOW_RST;
      win_high_r  <= WIN_HIGH_RST;
      local_max_r <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIN_LOW:   win_low_r   <= cfg_pwdata[IDX_W-1:0];
        REG_WIN_HIGH:  win_high_r  <= cfg_pwdata[IDX_W-1:0];
        REG_LOCAL_MAX: local_max_r <= cfg_pwdata[0];
        default:       ;
      endcase
    end
  end

  // shared squarer
  assign mul_sel = (state_r == ST_SQI) ? smp_i_r : smp_q_r;
  assign mag     = mul_sel[SAMPLE_W-1] ? SAMPLE_W'(-mul_sel) : mul_sel;
  assign sq      = PWR_W'(mag * mag);

  // candidate test for the sample before the current one
  assign lo_eff  = (win_low_r == '0) ? IDX_W'(1) : win_low_r;
  assign cur_idx = cnt_r - 1'b1;
  assign qualify = (cnt_r >= IDX_W'(2)) && (cur_idx >= lo_eff) && (cur_idx <= win_high_r)
                 && (pd1_r > best_pwr_r)
                 && (!local_max_r || ((pd1_r > pd2_r) && (pd1_r > acc_r)));

  assign in_acc    = in_tvalid & in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);
  assign div_start = (state_r == ST_FIN) && cand_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_SQI;
      ST_SQI:   state_nxt = ST_SQQ;
      ST_SQQ:   state_nxt = ST_JUDGE;
      ST_JUDGE: state_nxt = last_r ? ST_FIN : ST_IDLE;
      ST_FIN:   state_nxt = cand_r ? ST_DIV : ST_OUT;
      ST_DIV:   if (div_res.done) state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_i_r <= in_tdata[SAMPLE_W-1:0];
      smp_q_r <= in_tdata[IN_DATA_W-1:SAMPLE_W];
      last_r  <= in_tlast;
    end
    if (state_r == ST_SQI) begin
      acc_r <= sq;
    end else if (state_r == ST_SQQ) begin
      acc_r <= acc_r + sq;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n || out_load) begin
      cnt_r      <= '0;
      pd1_r      <= '0;
      pd2_r      <= '0;
      best_pwr_r <= '0;
      best_pos_r <= '0;
      best_l_r   <= '0;
      best_r_r   <= '0;
      cand_r     <= 1'b0;
    end else if (state_r == ST_JUDGE) begin
      if (qualify) begin
        best_pwr_r <= pd1_r;
        best_pos_r <= cur_idx;
        best_l_r   <= pd2_r;
        best_r_r   <= acc_r;
        cand_r     <= 1'b1;
      end
      pd2_r <= pd1_r;
      pd1_r <= acc_r;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  ppl_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .yl    (best_l_r),
    .yp    (best_pwr_r),
    .yr    (best_r_r),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && !cand_r) begin
      res_off_r  <= '0;
      res_flat_r <= 1'b0;
    end else if (state_r == ST_DIV && div_res.done) begin
      res_off_r  <= div_res.offset;
      res_flat_r <= div_res.flat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= OUT_DATA_W'({res_flat_r, cand_r,
                                  cand_r ? best_pwr_r : PWR_W'(0),
                                  res_off_r,
                                  cand_r ? best_pos_r : lo_eff});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_SQI)
    else $error("accepted sample did not start the squarer");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == ST_DIV)
    else $error("divider result outside the divide phase");

  a_no_peak_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[IDX_W+OFF_W+PWR_W] |->
      out_tdata[IDX_W+OFF_W+PWR_W-1:IDX_W] == '0 && !out_tdata[IDX_W+OFF_W+PWR_W+1])
    else $error("no-peak result carries offset, power or flat flag");

  a_flat_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[IDX_W+OFF_W+PWR_W+1] |-> out_tdata[IDX_W+OFF_W-1:IDX_W] == '0)
    else $error("flat fit result with nonzero offset");

endmodule
`default_nettype wire

@@ test/tb_power_peak_parabolic_locator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_peak_parabolic_locator
// self-checking testbench for the power peak locator
//
// frames of i/q samples go in on the input stream and one peak report per
// frame is checked field by field against a predictor kept inside this
// bench. directed frames cover the reset settings, both search modes, flat
// and saturated parabola fits, short frames and an empty window; random
// frames, mostly peak-shaped with noise mixed in, run under three patterns
// of sender and receiver stalls and many window settings.
// ----------------------------------------------------------------------------
module tb_power_peak_parabolic_locator;
  import ppl_pkg::*;

  typedef struct packed {
    logic                    pad_zero;
    logic                    flat;
    logic                    found;
    logic [PWR_W-1:0]        power;
    logic signed [OFF_W-1:0] offset;
    logic [IDX_W-1:0]        index;
  } peak_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // register copies and frame search state
  logic [IDX_W-1:0] win_low_q = WIN_LOW_RST;
  logic [IDX_W-1:0] win_high_q = WIN_HIGH_RST;
  logic             local_max_q = 1'b1;
  logic [IDX_W-1:0] sample_idx = '0;
  logic [PWR_W-1:0] power_prev = '0;
  logic [PWR_W-1:0] power_prev2 = '0;
  logic [PWR_W-1:0] best_power = '0;
  logic [IDX_W-1:0] best_idx = '0;
  logic [PWR_W-1:0] best_left = '0;
  logic [PWR_W-1:0] best_right = '0;
  logic             have_candidate = 1'b0;

  peak_report_t pending_peaks[$];

  int unsigned mismatch_count = 0;
  int unsigned samples_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned peaks_checked = 0;
  int unsigned empty_checked = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          burst_mode = 1'b0;

  power_peak_parabolic_locator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [15:0] sample_i, [31:16] sample_q
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [15:0] index, [33:16] offset, [65:34] power,
                                // [66] found, [67] flat, [71:68] zero
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= burst_mode || ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic [PWR_W-1:0] sample_power(logic signed [SAMPLE_W-1:0] si,
                                                    logic signed [SAMPLE_W-1:0] sq);
    logic signed [SAMPLE_W:0] ei;
    logic signed [SAMPLE_W:0] eq;
    logic [PWR_W-1:0]         mi;
    logic [PWR_W-1:0]         mq;
    ei = si;
    eq = sq;
    mi = PWR_W'(ei < 0 ? -ei : ei);
    mq = PWR_W'(eq < 0 ? -eq : eq);
    return mi * mi + mq * mq;
  endfunction

  // vertex of the parabola through yl, yp, yr, truncated and clipped to one sample
  function automatic logic signed [OFF_W-1:0] vertex_offset(logic [PWR_W-1:0] yl,
                                                            logic [PWR_W-1:0] yp,
                                                            logic [PWR_W-1:0] yr,
                                                            output logic flat);
    longint          num;
    longint          den;
    longint unsigned an;
    longint unsigned ad;
    longint unsigned rem;
    longint unsigned quo;
    bit              neg;
    num = longint'({32'b0, yl}) - longint'({32'b0, yr});
    den = 2 * (longint'({32'b0, yl}) + longint'({32'b0, yr}) - 2 * longint'({32'b0, yp}));
    flat = 1'b0;
    if (den == 0) begin
      flat = 1'b1;
      return '0;
    end
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (an >= ad) begin
      quo = 65536;
    end else begin
      rem = an;
      quo = 0;
      for (int k = 0; k < FRAC_STEPS; k++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= ad) begin
          rem = rem - ad;
          quo = quo | 1;
        end
      end
    end
    return neg ? -OFF_W'(quo) : OFF_W'(quo);
  endfunction

  function automatic void update_peak_search(logic signed [SAMPLE_W-1:0] si,
                                             logic signed [SAMPLE_W-1:0] sq,
                                             logic last);
    logic [PWR_W-1:0] pwr;
    logic [IDX_W-1:0] judged;
    logic [IDX_W-1:0] lo_eff;
    logic             ok;
    logic             flat;
    peak_report_t     rpt;
    pwr = sample_power(si, sq);
    lo_eff = (win_low_q == '0) ? IDX_W'(1) : win_low_q;
    if (sample_idx >= 2) begin
      judged = sample_idx - IDX_W'(1);
      ok = judged >= lo_eff && judged <= win_high_q && power_prev > best_power;
      if (local_max_q)
        ok = ok && power_prev > power_prev2 && power_prev > pwr;
      if (ok) begin
        best_power = power_prev;
        best_idx = judged;
        best_left = power_prev2;
        best_right = pwr;
        have_candidate = 1'b1;
      end
    end
    power_prev2 = power_prev;
    power_prev = pwr;
    sample_idx = sample_idx + IDX_W'(1);
    if (!last)
      return;
    rpt = '0;
    if (have_candidate) begin
      rpt.offset = vertex_offset(best_left, best_power, best_right, flat);
      rpt.index = best_idx;
      rpt.power = best_power;
      rpt.found = 1'b1;
      rpt.flat = flat;
    end else begin
      rpt.index = lo_eff;
    end
    pending_peaks.push_back(rpt);
    sample_idx = '0;
    power_prev = '0;
    power_prev2 = '0;
    best_power = '0;
    best_idx = '0;
    best_left = '0;
    best_right = '0;
    have_candidate = 1'b0;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    peak_report_t exp_r;
    peak_report_t act_r;
    if (rst_n && out_tvalid && out_tready) begin
      act_r = peak_report_t'(out_tdata[IDX_W+OFF_W+PWR_W+2:0]);
      if (pending_peaks.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result beat with none expected, got %h", $time, out_tdata);
      end else begin
        exp_r = pending_peaks.pop_front();
        check_field("peak_index", exp_r.index, act_r.index);
        check_field("peak_offset", longint'($signed(exp_r.offset)),
                    longint'($signed(act_r.offset)));
        check_field("peak_power", exp_r.power, act_r.power);
        check_field("peak_found", exp_r.found, act_r.found);
        check_field("flat_fit", exp_r.flat, act_r.flat);
        check_field("pad", 0, out_tdata[OUT_DATA_W-1:RES_W]);
        if (exp_r.found)
          peaks_checked++;
        else
          empty_checked++;
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
                             input logic signed [SAMPLE_W-1:0] sq, input logic last);
    if (!burst_mode) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {sq, si};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    update_peak_search(si, sq, last);
    samples_sent++;
    if (last)
      frames_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    @(posedge clk);
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] reg_sel, input logic [IDX_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'({reg_sel, 2'b00});
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (reg_sel)
      REG_WIN_LOW:   win_low_q = value;
      REG_WIN_HIGH:  win_high_q = value;
      REG_LOCAL_MAX: local_max_q = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_search(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi,
                            input logic local_max);
    cfg_write(REG_WIN_LOW, lo);
    cfg_write(REG_WIN_HIGH, hi);
    cfg_write(REG_LOCAL_MAX, IDX_W'(local_max));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] noise_component();
    case ($urandom_range(0, 7))
      0: return SAMPLE_W'(16'sh8000);
      1: return SAMPLE_W'(16'sh7fff);
      2: return '0;
      3: return SAMPLE_W'($signed($urandom_range(0, 6)) - 3);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic random_frames(input int unsigned n_items);
    int unsigned sent;
    int          len;
    int          pk;
    int          pk_gap;
    int          amp;
    int          amp_j;
    bit          noisy;
    bit          plateau;
    logic signed [SAMPLE_W-1:0] si;
    logic signed [SAMPLE_W-1:0] sq;
    logic signed [SAMPLE_W-1:0] tmp;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : $urandom_range(3, 16);
      pk = $urandom_range(0, len - 1);
      amp = ($urandom_range(0, 4) == 0) ? 32760 : $urandom_range(1, 32760);
      noisy = ($urandom_range(0, 3) == 0);
      plateau = ($urandom_range(0, 5) == 0);
      burst_mode = ($urandom_range(0, 5) == 0);
      for (int j = 0; j < len; j++) begin
        if (noisy) begin
          si = noise_component();
          sq = noise_component();
        end else begin
          pk_gap = (j > pk) ? j - pk : pk - j;
          if (plateau && pk_gap <= 1)
            amp_j = amp;
          else
            amp_j = (pk_gap > 8) ? 0 : amp >> (2 * pk_gap);
          amp_j = amp_j + $urandom_range(0, 3);
          si = $urandom_range(0, 1) ? SAMPLE_W'(amp_j) : SAMPLE_W'(-amp_j);
          sq = SAMPLE_W'($signed($urandom_range(0, 6)) - 3);
          if ($urandom_range(0, 1)) begin
            tmp = si;
            si = sq;
            sq = tmp;
          end
        end
        send_sample(si, sq, j == len - 1);
      end
      sent += len;
    end
    burst_mode = 1'b0;
  endtask

  task automatic random_search_setting();
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    case ($urandom_range(0, 5))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        lo = '1;
        hi = '0;
      end
      2: begin
        lo = IDX_W'($urandom_range(0, 3));
        hi = IDX_W'($urandom_range(lo, 20));
      end
      3: begin
        lo = IDX_W'($urandom_range(0, 20));
        hi = IDX_W'($urandom_range(0, 20));
      end
      default: begin
        lo = IDX_W'($urandom_range(0, 8));
        hi = IDX_W'($urandom_range(4, 70));
      end
    endcase
    set_search(lo, hi, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_defaults();
    // local max mode, window 1..65534, peak at full-scale corner
    send_sample(0, 0, 1'b0);
    send_sample(100, 0, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 1'b0);
    send_sample(16'sh7fff, 16'sh7fff, 1'b0);
    send_sample(0, -1, 1'b1);
    // single-sample and two-sample frames
    send_sample(-1, 16'sh7fff, 1'b1);
    send_sample(0, 0, 1'b0);
    send_sample(0, 0, 1'b1);
    wait_idle();
  endtask

  task automatic test_flat_and_saturated_fits();
    set_search(16'd1, 16'd1, 1'b0);
    // powers 1, 25, 49: zero curvature
    send_sample(1, 0, 1'b0);
    send_sample(5, 0, 1'b0);
    send_sample(7, 0, 1'b0);
    send_sample(0, 0, 1'b1);
    // rising edge at the window end: offset clips to plus one
    send_sample(0, 0, 1'b0);
    send_sample(4, 0, 1'b0);
    send_sample(5, 0, 1'b0);
    send_sample(0, 0, 1'b1);
    // falling edge: offset clips to minus one
    send_sample(5, 0, 1'b0);
    send_sample(4, 0, 1'b0);
    send_sample(0, 0, 1'b0);
    send_sample(0, 0, 1'b1);
    wait_idle();
  endtask

  task automatic test_plateau_and_empty_window();
    // window start 0 is raised to 1, first of equal powers wins
    set_search(16'd0, 16'hffff, 1'b0);
    send_sample(3, 4, 1'b0);
    send_sample(5, 0, 1'b0);
    send_sample(-4, -3, 1'b0);
    send_sample(0, -5, 1'b0);
    send_sample(0, 0, 1'b1);
    wait_idle();
    set_search(16'd10, 16'd5, 1'b1);
    send_sample(0, 0, 1'b0);
    send_sample(16'sh7fff, 0, 1'b0);
    send_sample(0, 0, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int r = 0; r < 4; r++) begin
      random_search_setting();
      random_frames(45);
      wait_idle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 16;
    recv_idle_pct = 77;
    test_reset_defaults();
    test_flat_and_saturated_fits();
    test_plateau_and_empty_window();
    test_random_traffic(16, 77);
    test_random_traffic(77, 16);
    test_random_traffic(0, 0);
    $display("sent %0d samples in %0d frames: both search modes, window extremes,",
             samples_sent, frames_sent);
    $display("flat and clipped fits, stalls on both sides; %0d peaks and %0d empty reports",
             peaks_checked, empty_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_peaks.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
